[hw/rtl/cbsd_pkg.sv]
// shared types and constants for the current burst shot detector
// no dependencies
package cbsd_pkg;

  localparam int WINDOW_LEN = 5;
  localparam int WIN_IDX_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int WIN_CNT_W = $clog2(WINDOW_LEN + 1);
  localparam int WIN_SUM_W = 16 + $clog2(WINDOW_LEN + 1);

  localparam logic [1:0] EV_START = 2'd0;
  localparam logic [1:0] EV_SHOT  = 2'd1;
  localparam logic [1:0] EV_STOP  = 2'd2;
  localparam logic [1:0] EV_REARM = 2'd3;

  localparam logic [2:0] REG_TRIGGER = 3'd0;
  localparam logic [2:0] REG_VALLEY  = 3'd1;
  localparam logic [2:0] REG_GAP     = 3'd2;
  localparam logic [2:0] REG_HOLD    = 3'd3;
  localparam logic [2:0] REG_LIMIT   = 3'd4;

  typedef struct packed {
    logic signed [15:0] raw_current_ma;
    logic [31:0]        time_ms;
  } sample_t;

  typedef struct packed {
    logic [1:0]         event_kind;
    logic [31:0]        event_time_ms;
    logic signed [15:0] level_ma;
    logic [15:0]        valley_drop_ma;
    logic [15:0]        shot_total;
    logic [31:0]        duration_ms;
    logic signed [15:0] average_ma;
    logic [15:0]        samples_taken;
    logic [15:0]        rate_decihertz;
    logic [31:0]        burst_number;
    logic               last_of_run;
  } result_t;

  // smoothed sample handed from front to back
  typedef struct packed {
    logic signed [15:0] level;
    logic [31:0]        time_ms;
  } level_item_t;

  typedef struct packed {
    logic [14:0] trigger_level_ma;
    logic [14:0] valley_depth_ma;
    logic [15:0] shot_gap_ms;
    logic [15:0] drop_hold_ms;
    logic [15:0] sample_limit;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic [34:0] num;
    logic [33:0] den;
  } div_req_t;

endpackage

[hw/rtl/current_burst_shot_detector_core.sv]
// Motor-current burst and shot detector. Each sample beat is smoothed by a
// moving average (a bit-serial divider), and the input takes no new sample
// until the level of the last one has been handed on. Levels pass a
// two-entry queue to the burst logic, which runs the divider for each stop
// average and, when needed, for the stop shot rate. A sample that ends a
// burst holds the burst logic through those divisions before its stop beat
// is offered. Registers sit at byte addresses 0,4,8,12,16 of the APB port.
module current_burst_shot_detector_core
  import cbsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  sample_t     in_data,
  input  logic        in_valid,
  output logic        in_ready,
  output result_t     out_data,
  output logic        out_valid,
  input  logic        out_ready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg;
  level_item_t f_data, q_data;
  logic f_valid, f_ready, q_valid, q_ready;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= {15'd1000, 15'd800, 16'd20, 16'd50, 16'd2000};
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_TRIGGER: cfg.trigger_level_ma <= pwdata[14:0];
        REG_VALLEY:  cfg.valley_depth_ma  <= pwdata[14:0];
        REG_GAP:     cfg.shot_gap_ms      <= pwdata[15:0];
        REG_HOLD:    cfg.drop_hold_ms     <= pwdata[15:0];
        REG_LIMIT:   cfg.sample_limit     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_TRIGGER: prdata = {17'd0, cfg.trigger_level_ma};
      REG_VALLEY:  prdata = {17'd0, cfg.valley_depth_ma};
      REG_GAP:     prdata = {16'd0, cfg.shot_gap_ms};
      REG_HOLD:    prdata = {16'd0, cfg.drop_hold_ms};
      REG_LIMIT:   prdata = {16'd0, cfg.sample_limit};
      default:     prdata = '0;
    endcase
  end

  cbsd_front u_front (
    .clk (clk), .rst (rst), .in_data (in_data), .in_valid (in_valid),
    .in_ready (in_ready), .lv_data (f_data), .lv_valid (f_valid), .lv_ready (f_ready)
  );

  cbsd_queue u_queue (
    .clk (clk), .rst (rst), .wr_data (f_data), .wr_valid (f_valid), .wr_ready (f_ready),
    .rd_data (q_data), .rd_valid (q_valid), .rd_ready (q_ready)
  );

  cbsd_back u_back (
    .clk (clk), .rst (rst), .cfg (cfg), .lv_data (q_data), .lv_valid (q_valid),
    .lv_ready (q_ready), .out_data (out_data), .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule

[hw/rtl/cbsd_divider.sv]
// round-half-away-from-zero divider, one quotient bit per cycle; front and back each hold their own
// depends on cbsd_pkg
module cbsd_divider
  import cbsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  div_req_t    req,
  input  logic        neg,
  output logic        done,
  output logic [34:0] quo
);

  logic [5:0]  cnt;
  logic        busy;
  logic        sgn;
  logic [34:0] q;
  logic [35:0] rem;
  logic [34:0] d;
  logic [35:0] rem_sh;

  assign rem_sh = {rem[34:0], q[34]};

  // computes (2|n|+d)/(2d) with d given pre-doubled, numerator pre-formed
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= 6'd35;
      q    <= req.num;
      rem  <= '0;
      d    <= {1'b0, req.den};
      sgn  <= neg;
    end else if (busy) begin
      if (rem_sh >= {1'b0, d}) begin
        rem <= rem_sh - {1'b0, d};
        q   <= {q[33:0], 1'b1};
      end else begin
        rem <= rem_sh;
        q   <= {q[33:0], 1'b0};
      end
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign quo = sgn ? (35'd0 - q) : q;

endmodule

[hw/rtl/cbsd_front.sv]
// front end: accepts samples and computes the moving average level
// depends on cbsd_pkg and cbsd_divider
module cbsd_front
  import cbsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  sample_t     in_data,
  input  logic        in_valid,
  output logic        in_ready,
  output level_item_t lv_data,
  output logic        lv_valid,
  input  logic        lv_ready
);

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_OUT} fstate_t;

  fstate_t state;
  logic signed [15:0] window_store [WINDOW_LEN];
  logic [WIN_IDX_W-1:0] window_pos;
  logic [WIN_CNT_W-1:0] window_fill;
  logic signed [WIN_SUM_W-1:0] window_sum;
  logic signed [WIN_SUM_W-1:0] sum_next;
  logic [WIN_CNT_W-1:0] fill_next;
  logic [31:0] t_hold;
  div_req_t req;
  logic neg;
  logic done;
  logic [34:0] quo;
  logic [WIN_SUM_W:0] mag;

  assign in_ready = (state == F_IDLE);
  assign lv_valid = (state == F_OUT);

  always_comb begin
    sum_next = window_sum + WIN_SUM_W'(in_data.raw_current_ma);
    if (window_fill == WIN_CNT_W'(WINDOW_LEN)) begin
      sum_next = sum_next - WIN_SUM_W'(window_store[window_pos]);
    end
    fill_next = (window_fill == WIN_CNT_W'(WINDOW_LEN)) ? window_fill : window_fill + 1'b1;
    mag = sum_next[WIN_SUM_W-1] ? (WIN_SUM_W+1)'(-sum_next) : (WIN_SUM_W+1)'(sum_next);
    req.start = in_valid && in_ready;
    req.num   = 35'({mag, 1'b0}) + 35'(fill_next);
    req.den   = 34'({fill_next, 1'b0});
    neg = sum_next[WIN_SUM_W-1];
  end

  cbsd_divider u_div (
    .clk (clk), .rst (rst), .req (req), .neg (neg), .done (done), .quo (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= F_IDLE;
      window_pos  <= '0;
      window_fill <= '0;
      window_sum  <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (req.start) begin
            window_store[window_pos] <= in_data.raw_current_ma;
            window_sum  <= sum_next;
            window_fill <= fill_next;
            window_pos  <= (window_pos == WIN_IDX_W'(WINDOW_LEN - 1)) ? '0 : window_pos + 1'b1;
            t_hold      <= in_data.time_ms;
            state       <= F_DIV;
          end
        end
        F_DIV: begin
          if (done) begin
            lv_data <= level_item_t'({quo[15:0], t_hold});
            state   <= F_OUT;
          end
        end
        F_OUT: if (lv_ready) state <= F_IDLE;
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/cbsd_queue.sv]
// two-entry queue between front and back
// depends on cbsd_pkg
module cbsd_queue
  import cbsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  level_item_t wr_data,
  input  logic        wr_valid,
  output logic        wr_ready,
  output level_item_t rd_data,
  output logic        rd_valid,
  input  logic        rd_ready
);

  level_item_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;

  assign wr_ready = (cnt != 2'd2);
  assign rd_valid = (cnt != 2'd0);
  assign rd_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= '0;
    end else begin
      if (wr_valid && wr_ready) begin
        mem[wp] <= wr_data;
        wp <= ~wp;
      end
      if (rd_valid && rd_ready) rp <= ~rp;
      cnt <= cnt + 2'((wr_valid && wr_ready)) - 2'((rd_valid && rd_ready));
    end
  end

endmodule

[hw/rtl/cbsd_back.sv]
// back end: burst phases, shot detection, stop statistics
// depends on cbsd_pkg and cbsd_divider
module cbsd_back
  import cbsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  level_item_t lv_data,
  input  logic        lv_valid,
  output logic        lv_ready,
  output result_t     out_data,
  output logic        out_valid,
  input  logic        out_ready
);

  typedef enum logic [2:0] {B_IDLE, B_AVG, B_RATE, B_SHOT, B_STOP, B_ONE} bstate_t;
  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_REC  = 2'd1;
  localparam logic [1:0] PH_COOL = 2'd2;

  bstate_t state;
  logic [1:0] phase;
  logic [31:0] burst_start_time;
  logic [15:0] burst_samples;
  logic signed [32:0] burst_sum;
  logic signed [15:0] burst_peak;
  logic [31:0] low_since_time;
  logic low_timing;
  logic [31:0] bursts_done;
  logic signed [15:0] previous_level, fall_start_level, valley_level, surge_peak;
  logic falling, armed;
  logic [31:0] last_shot_time;
  logic [15:0] shot_count;
  logic [31:0] third_shot_time, final_shot_time;

  // pending results of the current sample
  result_t shot_ev, stop_ev;
  result_t shot_ev_n, stop_ev_n, ev_n;
  logic have_shot, have_stop;

  level_item_t it;
  logic signed [15:0] lv;
  logic [31:0] now;
  logic signed [16:0] trig;
  logic lo_cond;
  logic signed [16:0] drop;

  // combinational next values for one sample
  logic [1:0] phase_n;
  logic [15:0] samples_n;
  logic signed [32:0] sum_n;
  logic signed [15:0] peak_n, prev_n, fall_n, valley_n, surge_n;
  logic low_timing_n, falling_n, armed_n;
  logic [31:0] low_since_n, last_shot_n, third_n, final_n, start_n;
  logic [15:0] shots_n;
  logic shot_hit, stop_hit, rearm_hit, start_hit;
  logic signed [16:0] drop_hit;
  logic go;

  div_req_t req;
  logic neg;
  logic done;
  logic [34:0] quo;
  logic [32:0] bmag;
  logic [31:0] span;
  logic [29:0] rnum;
  logic avg_go, rate_go, rate_needed;

  assign it = lv_data;
  assign lv = it.level;
  assign now = it.time_ms;
  assign trig = {2'b00, cfg.trigger_level_ma};
  assign lo_cond = 17'(lv) < trig;

  always_comb begin
    phase_n = phase; samples_n = burst_samples; sum_n = burst_sum; peak_n = burst_peak;
    prev_n = previous_level; fall_n = fall_start_level; valley_n = valley_level;
    surge_n = surge_peak; low_timing_n = low_timing; falling_n = falling; armed_n = armed;
    low_since_n = low_since_time; last_shot_n = last_shot_time; third_n = third_shot_time;
    final_n = final_shot_time; start_n = burst_start_time; shots_n = shot_count;
    shot_hit = 1'b0; stop_hit = 1'b0; rearm_hit = 1'b0; start_hit = 1'b0;
    drop = 17'(fall_start_level) - 17'(valley_level);
    drop_hit = '0;
    go = 1'b0;
    case (phase)
      PH_WAIT: begin
        if (17'(lv) > trig) begin
          start_hit = 1'b1; phase_n = PH_REC; start_n = now; samples_n = 16'd1;
          sum_n = 33'(lv); peak_n = lv; prev_n = lv; fall_n = lv; valley_n = lv;
          falling_n = 1'b0; last_shot_n = now; shots_n = '0; third_n = '0; final_n = '0;
          surge_n = lv; armed_n = 1'b0; low_timing_n = 1'b0;
        end
      end
      PH_REC: begin
        sum_n = burst_sum + 33'(lv);
        if (lv > burst_peak) peak_n = lv;
        if (burst_samples != 16'hFFFF) samples_n = burst_samples + 16'd1;
        if (17'(lv) <= trig) begin
          falling_n = 1'b0; prev_n = lv;
        end else begin
          go = 1'b1;
          if (lv > surge_peak) surge_n = lv;
          if (!armed) begin
            if (surge_n > 0 && 17'(lv) * 2 <= 17'(surge_n)) armed_n = 1'b1;
            else begin
              go = 1'b0; falling_n = 1'b0;
            end
          end
          if (go) begin
            if (lv < previous_level) begin
              if (!falling) begin
                fall_n = previous_level; falling_n = 1'b1;
              end
              valley_n = lv;
            end else if (lv > previous_level && falling) begin
              if (drop >= 17'(cfg.valley_depth_ma) &&
                  (now - last_shot_time) >= 32'(cfg.shot_gap_ms)) begin
                shot_hit = 1'b1; shots_n = shot_count + 16'd1;
                last_shot_n = now; final_n = now; drop_hit = drop;
                if (shots_n == 16'd3) third_n = now;
              end
              falling_n = 1'b0; valley_n = lv;
            end
          end
          prev_n = lv;
        end
        if (lo_cond) begin
          if (!low_timing) begin
            low_timing_n = 1'b1; low_since_n = now;
          end else if ((now - low_since_time) >= 32'(cfg.drop_hold_ms)) begin
            stop_hit = 1'b1;
          end
        end else low_timing_n = 1'b0;
        if (samples_n >= cfg.sample_limit) stop_hit = 1'b1;
        if (stop_hit) begin
          phase_n = PH_COOL; low_timing_n = 1'b0;
        end
      end
      default: begin
        if (lo_cond) begin
          if (!low_timing) begin
            low_timing_n = 1'b1; low_since_n = now;
          end else if ((now - low_since_time) >= 32'(cfg.drop_hold_ms)) begin
            rearm_hit = 1'b1; phase_n = PH_WAIT; low_timing_n = 1'b0;
          end
        end else low_timing_n = 1'b0;
      end
    endcase
  end

  // result beats built for the current sample; stop average and rate come later from the divider
  always_comb begin
    shot_ev_n = '0;
    shot_ev_n.event_kind = EV_SHOT;
    shot_ev_n.event_time_ms = now;
    shot_ev_n.level_ma = lv;
    shot_ev_n.valley_drop_ma = drop_hit[15:0];
    shot_ev_n.shot_total = shots_n;
    shot_ev_n.last_of_run = !stop_hit;
    stop_ev_n = '0;
    stop_ev_n.event_kind = EV_STOP;
    stop_ev_n.event_time_ms = now;
    stop_ev_n.level_ma = peak_n;
    stop_ev_n.shot_total = shots_n;
    stop_ev_n.duration_ms = now - burst_start_time;
    stop_ev_n.samples_taken = samples_n;
    stop_ev_n.burst_number = bursts_done + 32'd1;
    stop_ev_n.last_of_run = 1'b1;
    ev_n = '0;
    ev_n.event_kind = start_hit ? EV_START : EV_REARM;
    ev_n.event_time_ms = now;
    ev_n.level_ma = start_hit ? lv : 16'sd0;
    ev_n.last_of_run = 1'b1;
  end

  // average uses the sums of the sample just taken, rate the registered shot times
  assign bmag = sum_n[32] ? 33'(-sum_n) : 33'(sum_n);
  assign span = final_shot_time - third_shot_time;
  assign rnum = 30'(shot_count - 16'd3) * 30'd10000;
  assign rate_needed = (shot_count >= 16'd3) && (span != '0);
  assign avg_go = (state == B_IDLE) && lv_valid && lv_ready && stop_hit;
  assign rate_go = (state == B_AVG) && done && rate_needed;

  always_comb begin
    req.start = 1'b0; req.num = '0; req.den = '0; neg = 1'b0;
    if (avg_go) begin
      req.start = 1'b1;
      req.num = 35'({bmag, 1'b0}) + 35'(samples_n);
      req.den = 34'({samples_n, 1'b0});
      neg = sum_n[32];
    end
    if (rate_go) begin
      req.start = 1'b1;
      req.num = 35'({rnum, 1'b0}) + 35'(span);
      req.den = {1'b0, span, 1'b0};
    end
  end

  cbsd_divider u_div (
    .clk (clk), .rst (rst), .req (req), .neg (neg), .done (done), .quo (quo)
  );

  assign lv_ready = (state == B_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE; out_valid <= 1'b0; phase <= PH_WAIT;
      burst_start_time <= '0; burst_samples <= '0; burst_sum <= '0; burst_peak <= '0;
      low_since_time <= '0; low_timing <= 1'b0; bursts_done <= '0;
      previous_level <= '0; fall_start_level <= '0; valley_level <= '0; falling <= 1'b0;
      last_shot_time <= '0; shot_count <= '0; third_shot_time <= '0; final_shot_time <= '0;
      surge_peak <= '0; armed <= 1'b0; have_shot <= 1'b0; have_stop <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (lv_valid && lv_ready) begin
            phase <= phase_n; burst_start_time <= start_n;
            burst_sum <= sum_n; burst_peak <= peak_n;
            low_since_time <= low_since_n; low_timing <= low_timing_n;
            previous_level <= prev_n; fall_start_level <= fall_n; valley_level <= valley_n;
            falling <= falling_n; last_shot_time <= last_shot_n; shot_count <= shots_n;
            third_shot_time <= third_n; final_shot_time <= final_n; surge_peak <= surge_n;
            armed <= armed_n; burst_samples <= samples_n;
            shot_ev <= shot_ev_n;
            stop_ev <= stop_ev_n;
            have_shot <= shot_hit; have_stop <= stop_hit;
            if (stop_hit) bursts_done <= bursts_done + 32'd1;
            if (start_hit || rearm_hit) begin
              out_data <= ev_n;
              out_valid <= 1'b1;
            end else if (stop_hit) begin
              state <= B_AVG;
            end else if (shot_hit) state <= B_SHOT;
          end
        end
        B_AVG: if (done) begin
          stop_ev.average_ma <= quo[15:0];
          if (rate_needed) state <= B_RATE;
          else state <= have_shot ? B_SHOT : B_STOP;
        end
        B_RATE: if (done) begin
          stop_ev.rate_decihertz <= (quo > 35'd65535) ? 16'hFFFF : quo[15:0];
          state <= have_shot ? B_SHOT : B_STOP;
        end
        B_SHOT: if (!out_valid) begin
          out_data <= shot_ev; out_valid <= 1'b1;
          state <= have_stop ? B_STOP : B_IDLE;
        end
        B_STOP: if (!out_valid) begin
          out_data <= stop_ev; out_valid <= 1'b1;
          state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

[tb/current_burst_shot_detector_core_tb.sv]
// self-checking testbench for current_burst_shot_detector_core
// depends on cbsd_pkg and the core; predicts every event beat in the bench itself
module current_burst_shot_detector_core_tb;
  import cbsd_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 400;
  localparam int STALL_CYCLES = 600;
  localparam int ITEM_TARGET = 1800;

  typedef enum {WAITING, RECORDING, COOLDOWN} burst_phase_t;

  logic        clk;
  logic        rst;
  sample_t     in_data;
  logic        in_valid;
  logic        in_ready;
  result_t     out_data;
  logic        out_valid;
  logic        out_ready;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  current_burst_shot_detector_core uut (
    .clk(clk), .rst(rst),
    .in_data(in_data), .in_valid(in_valid), .in_ready(in_ready),
    .out_data(out_data), .out_valid(out_valid), .out_ready(out_ready),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  int        error_count = 0;
  int        items_sent = 0;
  int        idle_cycles = 0;
  bit        sender_gaps_on = 1;
  bit        stall_request = 0;
  bit [31:0] now_ms = 0;

  result_t expected_events[$];
  result_t step_events[$];

  // detector configuration as the block should hold it
  int        cfg_trig = 1000;
  int        cfg_valley = 800;
  bit [31:0] cfg_gap = 20;
  bit [31:0] cfg_hold = 50;
  bit [31:0] cfg_limit = 2000;

  // detector state
  burst_phase_t ph = WAITING;
  int        win[WINDOW_LEN];
  int        win_pos = 0;
  int        win_fill = 0;
  int        win_sum = 0;
  bit [31:0] b_start = 0;
  int        b_samples = 0;
  longint    b_sum = 0;
  int        b_peak = 0;
  bit [31:0] low_since = 0;
  bit        low_on = 0;
  bit [31:0] bursts = 0;
  int        prev_lvl = 0;
  int        fall_lvl = 0;
  int        valley_lvl = 0;
  bit        falling_f = 0;
  bit [31:0] last_shot_t = 0;
  bit [31:0] third_t = 0;
  bit [31:0] final_t = 0;
  int        shots = 0;
  int        surge = 0;
  bit        armed_f = 0;

  task report(input string msg);
    $display("ERROR: %s", msg);
    error_count++;
  endtask

  function automatic int round_div(longint num, longint den);
    if (den <= 0) return 0;
    if (num >= 0) return int'((2 * num + den) / (2 * den));
    return -int'((2 * (-num) + den) / (2 * den));
  endfunction

  function automatic int clip16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic result_t make_event(logic [1:0] kind, bit [31:0] t, int level, int drop,
                                         int shot_no, bit [31:0] dur, int avg, int samples,
                                         int rate, bit [31:0] num);
    result_t r;
    r.event_kind = kind;
    r.event_time_ms = t;
    r.level_ma = level[15:0];
    r.valley_drop_ma = drop[15:0];
    r.shot_total = shot_no[15:0];
    r.duration_ms = dur;
    r.average_ma = avg[15:0];
    r.samples_taken = samples[15:0];
    r.rate_decihertz = rate[15:0];
    r.burst_number = num;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  task track_shots(input int level, input bit [31:0] t);
    bit [31:0] since;
    int        drop;
    since = t - last_shot_t;
    if (level <= cfg_trig) begin
      falling_f = 0;
      prev_lvl = level;
      return;
    end
    if (level > surge) surge = level;
    if (!armed_f) begin
      // surge must decay to half its peak before counting
      if (surge > 0 && 2 * level <= surge) begin
        armed_f = 1;
      end else begin
        falling_f = 0;
        prev_lvl = level;
        return;
      end
    end
    if (level < prev_lvl) begin
      if (!falling_f) begin
        fall_lvl = prev_lvl;
        falling_f = 1;
      end
      valley_lvl = level;
    end else if (level > prev_lvl && falling_f) begin
      drop = fall_lvl - valley_lvl;
      if (drop >= cfg_valley && since >= cfg_gap) begin
        shots = (shots + 1) & 16'hFFFF;
        last_shot_t = t;
        final_t = t;
        if (shots == 3) third_t = t;
        step_events.push_back(make_event(EV_SHOT, t, level, drop, shots, 0, 0, 0, 0, 0));
      end
      falling_f = 0;
      valley_lvl = level;
    end
    prev_lvl = level;
  endtask

  task close_burst(input bit [31:0] t);
    longint    num;
    longint    r;
    bit [31:0] span;
    int        avg;
    int        rate;
    avg = round_div(b_sum, b_samples);
    rate = 0;
    span = final_t - third_t;
    if (shots >= 3 && span != 0) begin
      num = longint'(shots - 3) * 10000;
      r = (2 * num + longint'(span)) / (2 * longint'(span));
      rate = (r > 65535) ? 65535 : int'(r);
    end
    bursts++;
    step_events.push_back(make_event(EV_STOP, t, b_peak, 0, shots, t - b_start, avg,
                                     b_samples, rate, bursts));
    ph = COOLDOWN;
    low_on = 0;
  endtask

  // low hold timer shared by recording and cooldown; returns 1 when the hold expires
  function automatic bit low_hold_done(int level, bit [31:0] t);
    bit [31:0] el;
    el = t - low_since;
    if (level >= cfg_trig) begin
      low_on = 0;
      return 0;
    end
    if (!low_on) begin
      low_on = 1;
      low_since = t;
      return 0;
    end
    return el >= cfg_hold;
  endfunction

  task predict_events(input sample_t s);
    int        raw;
    int        p;
    int        level;
    bit        ended;
    bit [31:0] t;
    raw = s.raw_current_ma;
    t = s.time_ms;
    step_events.delete();
    p = win_pos % WINDOW_LEN;
    if (win_fill >= WINDOW_LEN) win_sum -= win[p];
    win[p] = raw;
    win_sum += raw;
    win_pos = (p + 1) % WINDOW_LEN;
    if (win_fill < WINDOW_LEN) win_fill++;
    level = round_div(win_sum, win_fill);
    case (ph)
      WAITING: begin
        if (level > cfg_trig) begin
          ph = RECORDING;
          b_start = t;
          b_samples = 1;
          b_sum = level;
          b_peak = level;
          prev_lvl = level;
          fall_lvl = level;
          valley_lvl = level;
          falling_f = 0;
          last_shot_t = t;
          shots = 0;
          third_t = 0;
          final_t = 0;
          surge = level;
          armed_f = 0;
          low_on = 0;
          step_events.push_back(make_event(EV_START, t, level, 0, 0, 0, 0, 0, 0, 0));
        end
      end
      RECORDING: begin
        ended = 0;
        b_sum += level;
        if (level > b_peak) b_peak = level;
        if (b_samples < 16'hFFFF) b_samples++;
        track_shots(level, t);
        if (low_hold_done(level, t)) begin
          close_burst(t);
          ended = 1;
        end
        if (!ended && b_samples >= cfg_limit) close_burst(t);
      end
      default: begin
        if (low_hold_done(level, t)) begin
          ph = WAITING;
          low_on = 0;
          step_events.push_back(make_event(EV_REARM, t, 0, 0, 0, 0, 0, 0, 0, 0));
        end
      end
    endcase
    if (step_events.size() > 0) step_events[$].last_of_run = 1'b1;
    foreach (step_events[i]) expected_events.push_back(step_events[i]);
  endtask

  task send_sample(input sample_t s);
    int gap;
    int r;
    gap = 0;
    if (sender_gaps_on) begin
      r = $urandom_range(0, 99);
      if (r >= 95) gap = $urandom_range(20, 80);
      else if (r >= 70) gap = $urandom_range(1, 4);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= s;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_events(s);
    items_sent++;
  endtask

  // next sample on the running time base, mostly 1..3 ms apart
  task send_level(input int raw);
    sample_t s;
    if ($urandom_range(0, 99) < 2) now_ms += $urandom_range(100, 5000);
    else now_ms += $urandom_range(1, 3);
    s.raw_current_ma = 16'(clip16(raw));
    s.time_ms = now_ms;
    send_sample(s);
  endtask

  task send_noise(input int count);
    sample_t s;
    repeat (count) begin
      if ($urandom_range(0, 1)) now_ms = $urandom;
      else now_ms += $urandom_range(0, 200);
      s.raw_current_ma = 16'($urandom_range(0, 65535));
      s.time_ms = now_ms;
      send_sample(s);
    end
  endtask

  // surge, a train of dips off a base above trigger, then a tail below trigger
  task play_burst();
    int depth;
    int base;
    int surge_lvl;
    int period;
    int dip_len;
    int tail;
    repeat (1) begin
      depth = cfg_valley + $urandom_range(100, 1500);
      base = clip16(cfg_trig + depth + $urandom_range(200, 2000));
      surge_lvl = clip16(2 * base + $urandom_range(500, 3000));
      repeat ($urandom_range(3, 6)) send_level(surge_lvl + $urandom_range(0, 400));
      repeat ($urandom_range(2, 6)) begin
        period = $urandom_range(6, 20);
        dip_len = $urandom_range(3, 8);
        repeat (period) begin
          if ($urandom_range(0, 39) == 0) send_noise(1);
          else send_level(base + $urandom_range(0, 200) - 100);
        end
        repeat (dip_len) send_level(base - depth - $urandom_range(0, 300));
      end
      tail = (cfg_hold > 60) ? 60 : int'(2 * cfg_hold + 10);
      repeat (tail) send_level(cfg_trig - $urandom_range(100, 2000));
    end
  endtask

  task wait_drained();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_TRIGGER: cfg_trig = int'(value[14:0]);
      REG_VALLEY:  cfg_valley = int'(value[14:0]);
      REG_GAP:     cfg_gap = 32'(value[15:0]);
      REG_HOLD:    cfg_hold = 32'(value[15:0]);
      REG_LIMIT:   cfg_limit = 32'(value[15:0]);
      default: ;
    endcase
  endtask

  task load_config(input int trig, input int valley, input int gap, input int hold,
                   input int limit);
    wait_drained();
    write_reg(REG_TRIGGER, trig);
    write_reg(REG_VALLEY, valley);
    write_reg(REG_GAP, gap);
    write_reg(REG_HOLD, hold);
    write_reg(REG_LIMIT, limit);
  endtask

  task test_extremes();
    now_ms = 32'hFFFF_FFF8;
    send_level(32767);
    send_level(32767);
    repeat (6) send_level(-32768);
    send_level(16'sh5555);
    send_level(-21846);
    send_level(0);
    send_level(-1);
    send_level(32767);
    repeat (10) send_level(-32768);
  endtask

  task test_default_bursts();
    repeat (3) play_burst();
  endtask

  task test_config_sweep();
    load_config(0, 0, 0, 0, 1);
    play_burst();
    load_config(32767, 32767, 65535, 65535, 65535);
    play_burst();
    repeat (3) begin
      load_config($urandom_range(200, 3000), $urandom_range(100, 1500), $urandom_range(0, 40),
                  $urandom_range(0, 80), $urandom_range(20, 300));
      repeat (2) play_burst();
    end
  endtask

  task test_backpressure();
    load_config(1000, 800, 20, 50, 2000);
    sender_gaps_on = 0;
    stall_request = 1;
    repeat (2) play_burst();
    sender_gaps_on = 1;
  endtask

  task test_random_mix();
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 4) == 0) send_noise($urandom_range(5, 20));
      else play_burst();
    end
  endtask

  // result side: random ready with occasional long holds
  initial begin
    out_ready = 1'b0;
    forever begin
      if (stall_request) begin
        out_ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        stall_request = 0;
      end else if ($urandom_range(0, 9) == 0) begin
        out_ready <= 1'b1;
        repeat (200) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk);
        out_ready <= 1'b0;
        if ($urandom_range(0, 19) == 0) repeat ($urandom_range(20, 80)) @(posedge clk);
        else repeat ($urandom_range(1, 3)) @(posedge clk);
      end
    end
  end

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want) report($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_events.size() == 0) begin
        report($sformatf("unexpected event beat kind %0d", out_data.event_kind));
      end else begin
        want = expected_events.pop_front();
        check_field("event_kind", out_data.event_kind, want.event_kind);
        check_field("event_time_ms", out_data.event_time_ms, want.event_time_ms);
        check_field("level_ma", out_data.level_ma, want.level_ma);
        check_field("valley_drop_ma", out_data.valley_drop_ma, want.valley_drop_ma);
        check_field("shot_total", out_data.shot_total, want.shot_total);
        check_field("duration_ms", out_data.duration_ms, want.duration_ms);
        check_field("average_ma", out_data.average_ma, want.average_ma);
        check_field("samples_taken", out_data.samples_taken, want.samples_taken);
        check_field("rate_decihertz", out_data.rate_decihertz, want.rate_decihertz);
        check_field("burst_number", out_data.burst_number, want.burst_number);
        check_field("last_of_run", out_data.last_of_run, want.last_of_run);
      end
    end
  end

  // watchdog on cycles with no beat on any port
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_default_bursts();
    test_config_sweep();
    test_backpressure();
    test_random_mix();
    wait_drained();
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/cbsd_pkg.sv
hw/rtl/cbsd_divider.sv
hw/rtl/cbsd_front.sv
hw/rtl/cbsd_queue.sv
hw/rtl/cbsd_back.sv
hw/rtl/current_burst_shot_detector_core.sv
tb/current_burst_shot_detector_core_tb.sv
